/* rtl/core/translated_text_extractor_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the extractor RTL
// Both macros expect clk_i and rst_ni to be visible at the point of use.
// ----------------------------------------------------------------------------
`ifndef TRANSLATED_TEXT_EXTRACTOR_UNIT_DEFINES_SVH
`define TRANSLATED_TEXT_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TTX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TTX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ttx_pkg.sv */
// ----------------------------------------------------------------------------
// ttx_pkg
// Types, codes and character constants of the text extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttx_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_HEADER = 3'd0,
    MODE_SEEK   = 3'd1,
    MODE_STRING = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_SKIP   = 3'd5,
    MODE_CLOSE  = 3'd6,
    MODE_DONE   = 3'd7
  } mode_e;

  // Result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Final status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_HEADER = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  // Characters
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [1:0] HEADER_BRACKETS = 2'd3;
  localparam int         HELD_MAX        = 3;   // \u digits held before decode
  localparam int         DATA_MAX        = 4;   // data bytes one input can yield

  // One queue entry: the results caused by one input byte
  typedef struct packed {
    logic [DATA_MAX-1:0][7:0] data;
    logic [2:0]               data_cnt;
    logic                     has_status;
    logic [1:0]               status;
  } entry_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_upper_hex(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [7:0] v;
    if (b <= 8'h39)      v = b - 8'h30;
    else if (b >= 8'h61) v = b - 8'h57;
    else                 v = b - 8'h37;
    return v[3:0];
  endfunction

  // Re-create the digit as it was written
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic up);
    logic [7:0] r;
    if (nib < 4'd10)  r = 8'h30 + {4'd0, nib};
    else if (up)      r = 8'h37 + {4'd0, nib};
    else              r = 8'h57 + {4'd0, nib};
    return r;
  endfunction

endpackage

/* rtl/core/ttx_front.sv */
// ----------------------------------------------------------------------------
// ttx_front
// Parser front end: takes one body byte a cycle unless the queue is full,
// updates parse state and writes all results of that byte as one queue entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttx_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output ttx_pkg::entry_t q_entry_o
);
  import ttx_pkg::*;

  mode_e      mode_q, mode_d;
  logic [1:0] hcnt_q, hcnt_d;
  logic       prev_q, prev_d;
  logic [11:0] hex_q, hex_d;     // held \u digits, newest in the low nibble
  logic [1:0] hexn_q, hexn_d;
  logic [2:0] upper_q, upper_d;
  logic       any_q, any_d;

  entry_t     ent;
  logic [2:0] n;
  logic [15:0] code;
  logic       any_now;
  logic       fire;
  logic [1:0] pos;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    mode_d  = mode_q;
    hcnt_d  = hcnt_q;
    prev_d  = prev_q;
    hex_d   = hex_q;
    hexn_d  = hexn_q;
    upper_d = upper_q;
    any_d   = any_q;
    ent     = '0;
    n       = 3'd0;
    code    = 16'd0;
    pos     = 2'd0;

    case (mode_q)
      MODE_HEADER: begin
        if (hcnt_q == HEADER_BRACKETS && in_byte_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
          hcnt_d = 2'd0;
          prev_d = 1'b0;
        end else if (in_byte_i == CH_LBRACK) begin
          if (hcnt_q < HEADER_BRACKETS) hcnt_d = hcnt_q + 2'd1;
        end else begin
          hcnt_d = 2'd0;
        end
      end
      MODE_SEEK: begin
        if (prev_q && in_byte_i == CH_QUOTE) begin
          mode_d = MODE_STRING;
          prev_d = 1'b0;
        end else begin
          prev_d = (in_byte_i == CH_LBRACK);
        end
      end
      MODE_STRING: begin
        if (in_byte_i == CH_BSLASH)     mode_d = MODE_ESCAPE;
        else if (in_byte_i == CH_QUOTE) mode_d = MODE_SKIP;
        else begin
          ent.data[n[1:0]] = in_byte_i;
          n = n + 3'd1;
        end
      end
      MODE_ESCAPE: begin
        mode_d = MODE_STRING;
        if (in_byte_i == CH_LOW_N) begin
          ent.data[n[1:0]] = CH_LF;
          n = n + 3'd1;
        end else if (in_byte_i == CH_LOW_T) begin
          ent.data[n[1:0]] = CH_TAB;
          n = n + 3'd1;
        end else if (in_byte_i == CH_LOW_U) begin
          hex_d   = 12'd0;
          hexn_d  = 2'd0;
          upper_d = 3'd0;
          mode_d  = MODE_HEX;
        end else begin
          ent.data[n[1:0]] = in_byte_i;
          n = n + 3'd1;
        end
      end
      MODE_HEX: begin
        if (!is_hex(in_byte_i)) begin
          // invalid \u: give back the held digits, then treat as string text
          for (int i = 0; i < HELD_MAX; i++) begin
            if (i < int'(hexn_q)) begin
              pos = 2'(int'(hexn_q) - 1 - i);
              ent.data[n[1:0]] = hex_char(hex_q[4*pos +: 4], upper_q[i]);
              n = n + 3'd1;
            end
          end
          hex_d   = 12'd0;
          hexn_d  = 2'd0;
          upper_d = 3'd0;
          mode_d  = MODE_STRING;
          if (in_byte_i == CH_BSLASH)     mode_d = MODE_ESCAPE;
          else if (in_byte_i == CH_QUOTE) mode_d = MODE_SKIP;
          else begin
            ent.data[n[1:0]] = in_byte_i;
            n = n + 3'd1;
          end
        end else if (hexn_q == 2'(HELD_MAX)) begin
          code = {hex_q, hex_nibble(in_byte_i)};
          if (code < 16'h0080) begin
            ent.data[0] = code[7:0];
            n = 3'd1;
          end else if (code < 16'h0800) begin
            ent.data[0] = {3'b110, code[10:6]};
            ent.data[1] = {2'b10, code[5:0]};
            n = 3'd2;
          end else begin
            ent.data[0] = {4'b1110, code[15:12]};
            ent.data[1] = {2'b10, code[11:6]};
            ent.data[2] = {2'b10, code[5:0]};
            n = 3'd3;
          end
          hex_d   = 12'd0;
          hexn_d  = 2'd0;
          upper_d = 3'd0;
          mode_d  = MODE_STRING;
        end else begin
          hex_d = {hex_q[7:0], hex_nibble(in_byte_i)};
          upper_d[hexn_q] = is_upper_hex(in_byte_i);
          hexn_d = hexn_q + 2'd1;
        end
      end
      MODE_SKIP: begin
        if (in_byte_i == CH_RBRACK) mode_d = MODE_CLOSE;
      end
      MODE_CLOSE: begin
        if (in_byte_i == CH_RBRACK) begin
          mode_d = MODE_DONE;
        end else begin
          mode_d = MODE_SEEK;
          prev_d = (in_byte_i == CH_LBRACK);
        end
      end
      default: ;
    endcase

    if (in_last_i) begin
      // body ends mid-escape: flush what is pending
      if (mode_d == MODE_ESCAPE) begin
        ent.data[n[1:0]] = CH_BSLASH;
        n = n + 3'd1;
      end else if (mode_d == MODE_HEX) begin
        for (int i = 0; i < HELD_MAX; i++) begin
          if (i < int'(hexn_d)) begin
            pos = 2'(int'(hexn_d) - 1 - i);
            ent.data[n[1:0]] = hex_char(hex_d[4*pos +: 4], upper_d[i]);
            n = n + 3'd1;
          end
        end
      end
    end

    any_now      = any_q || (n != 3'd0);
    ent.data_cnt = n;

    if (in_last_i) begin
      ent.has_status = 1'b1;
      if (mode_d == MODE_HEADER) ent.status = ST_NO_HEADER;
      else if (any_now)          ent.status = ST_OK;
      else                       ent.status = ST_EMPTY;
      mode_d  = MODE_HEADER;
      hcnt_d  = 2'd0;
      prev_d  = 1'b0;
      hex_d   = 12'd0;
      hexn_d  = 2'd0;
      upper_d = 3'd0;
      any_d   = 1'b0;
    end else begin
      any_d = any_now;
    end
  end

  assign q_entry_o = ent;
  assign q_push_o  = fire && (ent.has_status || (ent.data_cnt != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      hcnt_q  <= 2'd0;
      prev_q  <= 1'b0;
      hex_q   <= 12'd0;
      hexn_q  <= 2'd0;
      upper_q <= 3'd0;
      any_q   <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      hcnt_q  <= hcnt_d;
      prev_q  <= prev_d;
      hex_q   <= hex_d;
      hexn_q  <= hexn_d;
      upper_q <= upper_d;
      any_q   <= any_d;
    end
  end

endmodule

/* rtl/core/ttx_queue.sv */
// ----------------------------------------------------------------------------
// ttx_queue
// Small register queue of result entries between parser and output side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "translated_text_extractor_unit_defines.svh"

module ttx_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ttx_pkg::entry_t wdata_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ttx_pkg::entry_t rdata_o
);
  import ttx_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (pop_i && !push_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  `TTX_ASSERT_NOW(a_push_not_full, push_i, !full_o, "push into full queue")
  `TTX_ASSERT_NOW(a_pop_not_empty, pop_i, valid_o, "pop from empty queue")
  `TTX_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule

/* rtl/core/ttx_back.sv */
// ----------------------------------------------------------------------------
// ttx_back
// Output side: holds one entry and hands out its items one per cycle while
// out_ready_i is high, data bytes first, then the status item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "translated_text_extractor_unit_defines.svh"

module ttx_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  ttx_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            kind_o,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      status_o,
  output logic            end_of_run_o
);
  import ttx_pkg::*;

  entry_t     cur_q;
  logic       busy_q;
  logic [2:0] idx_q;
  logic [2:0] total;
  logic       is_data;
  logic       take;
  logic       done;
  logic       load;

  assign total   = cur_q.data_cnt + {2'd0, cur_q.has_status};
  assign is_data = (idx_q < cur_q.data_cnt);

  assign out_valid_o  = busy_q;
  assign kind_o       = is_data ? KIND_DATA : KIND_STATUS;
  assign out_byte_o   = is_data ? cur_q.data[idx_q[1:0]] : 8'd0;
  assign status_o     = is_data ? ST_OK : cur_q.status;
  assign end_of_run_o = (idx_q == total - 3'd1);

  assign take    = busy_q && out_ready_i;
  assign done    = take && end_of_run_o;
  assign load    = (!busy_q || done) && q_valid_i;
  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= 3'd0;
    end else if (done) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (take) begin
      idx_q  <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_entry_i;
  end

  // status is always the last item of its byte
  `TTX_ASSERT_NOW(a_status_last, out_valid_o && kind_o == KIND_STATUS, end_of_run_o, "status not last")
  `TTX_ASSERT_NOW(a_entry_nonempty, out_valid_o, total != 3'd0 && idx_q < total, "item index out of entry")
  `TTX_ASSERT_NEXT(a_hold_valid, out_valid_o && !out_ready_i, out_valid_o, "stalled item dropped")

endmodule

/* rtl/core/translated_text_extractor_unit.sv */
// ----------------------------------------------------------------------------
// translated_text_extractor_unit
// Streaming extractor of quoted text from a nested-array response body.
// ----------------------------------------------------------------------------
// Accepts one body byte per cycle while the result queue (QueueDepth entries)
// has room; each byte gives 0 to 5 result items, which leave one per cycle while
// out_ready_i is high, so the single-item output port sets the input rate over a
// stretch. A byte's results are written to the queue when the byte is taken and
// show on the output once the output side has loaded them into its holding
// register. The byte flagged last also yields the status item (0 ok, 1 no
// header, 2 nothing extracted) and returns the parser to the header search for
// the next body.
`timescale 1ns / 1ps

module translated_text_extractor_unit #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] status_o,
  output logic       end_of_run_o
);
  import ttx_pkg::*;

  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t q_wdata;
  entry_t q_rdata;

  ttx_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (q_wdata)
  );

  ttx_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  ttx_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_entry_i    (q_rdata),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .status_o     (status_o),
    .end_of_run_o (end_of_run_o)
  );

endmodule
